// ===== design/rdcs_pkg.sv =====
// Shared types, constants and the byte filter of the record deframer / scrubber.
`timescale 1ns / 1ps

package rdcs_pkg;

    localparam logic [7:0]  SPACE_CODE   = 8'd32;
    localparam logic [7:0]  UPPER_KEEP   = 8'd128;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [15:0] HEADER_BYTES = 16'd4;
    localparam int          KEEP_COUNT   = 10;

    localparam logic [7:0] KEEP_LIST [KEEP_COUNT] = '{
        8'd9, 8'd128, 8'd196, 8'd199, 8'd214, 8'd220, 8'd223, 8'd228, 8'd246, 8'd252
    };

    // Header parser position; codes above HDR_PAYLOAD behave as payload
    typedef enum logic [2:0] {
        HDR_LEN_HI  = 3'd0,
        HDR_LEN_LO  = 3'd1,
        HDR_SKIP_A  = 3'd2,
        HDR_SKIP_B  = 3'd3,
        HDR_PAYLOAD = 3'd4
    } hdr_state_t;

    // Filter result for one byte
    typedef struct packed {
        logic [7:0] value;
        logic       replaced;
    } filt_t;

    // Command passed from the front to the back through the queue
    typedef struct packed {
        logic [7:0] value;
        logic       replaced;
        logic       emit_byte;
        logic       emit_end;
    } cmd_t;

    // Keep whitelist bytes, 32..128 and, in direct mode, newline; replace everything else by a space
    function automatic filt_t filter_byte(logic [7:0] b, logic direct);
        filt_t res;
        logic  keep;
        keep = direct && (b == NEWLINE_CODE);
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            if (b == KEEP_LIST[i])
            begin
                keep = 1'b1;
            end
        end
        if (!keep && ((b < SPACE_CODE) || (b > UPPER_KEEP)))
        begin
            res.value    = SPACE_CODE;
            res.replaced = 1'b1;
        end
        else
        begin
            res.value    = b;
            res.replaced = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== design/rdcs_if.sv =====
// Stream and configuration channel interfaces of the record deframer / scrubber.
`timescale 1ns / 1ps

interface rdcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface rdcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       record_end;

    modport source (output valid, output out_byte, output was_replaced, output record_end,
                    input ready);
    modport sink   (input valid, input out_byte, input was_replaced, input record_end,
                    output ready);
endinterface

interface rdcs_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rdcs_front.sv =====
// Front end: accepts bytes, tracks record headers and issues output commands.
`timescale 1ns / 1ps

module rdcs_front (
    input  logic              clk,
    input  logic              rst_n,
    rdcs_in_if.sink           in_ch,
    rdcs_cfg_if.sink          cfg_ch,
    input  logic              queue_full,
    output logic              push,
    output rdcs_pkg::cmd_t    cmd
);

    rdcs_pkg::hdr_state_t state_reg, state_next;
    logic [7:0]           length_high_reg, length_high_next;
    logic [15:0]          payload_left_reg, payload_left_next;
    logic                 direct_mode_reg;

    logic                 accept;
    rdcs_pkg::filt_t      filt;
    logic [15:0]          after_hdr;
    logic [15:0]          after_byte;

    assign in_ch.ready  = !queue_full;
    assign cfg_ch.ready = 1'b1;
    assign accept       = in_ch.valid && in_ch.ready;

    assign filt       = rdcs_pkg::filter_byte(in_ch.data_byte, direct_mode_reg);
    assign after_hdr  = (payload_left_reg < rdcs_pkg::HEADER_BYTES) ? 16'd0
                      : payload_left_reg - rdcs_pkg::HEADER_BYTES;
    assign after_byte = (payload_left_reg != 16'd0) ? payload_left_reg - 16'd1 : 16'd0;

    // Hold the mode register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_mode_reg <= 1'b0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            direct_mode_reg <= cfg_ch.data;
        end
    end

    // Advance the header parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rdcs_pkg::HDR_LEN_HI;
            length_high_reg  <= 8'd0;
            payload_left_reg <= 16'd0;
        end
        else
        begin
            state_reg        <= state_next;
            length_high_reg  <= length_high_next;
            payload_left_reg <= payload_left_next;
        end
    end

    // Classify the accepted byte and compute the next parser state
    always_comb
    begin
        state_next        = state_reg;
        length_high_next  = length_high_reg;
        payload_left_next = payload_left_reg;
        cmd.value         = filt.value;
        cmd.replaced      = filt.replaced;
        cmd.emit_byte     = 1'b0;
        cmd.emit_end      = 1'b0;

        if (direct_mode_reg)
        begin
            cmd.emit_byte = 1'b1;
            if (in_ch.end_of_input)
            begin
                state_next        = rdcs_pkg::HDR_LEN_HI;
                length_high_next  = 8'd0;
                payload_left_next = 16'd0;
            end
        end
        else
        begin
            case (state_reg)
                rdcs_pkg::HDR_LEN_HI:
                begin
                    length_high_next = in_ch.data_byte;
                    state_next       = rdcs_pkg::HDR_LEN_LO;
                end
                rdcs_pkg::HDR_LEN_LO:
                begin
                    payload_left_next = {length_high_reg, in_ch.data_byte};
                    state_next        = rdcs_pkg::HDR_SKIP_A;
                end
                rdcs_pkg::HDR_SKIP_A:
                begin
                    state_next = rdcs_pkg::HDR_SKIP_B;
                end
                rdcs_pkg::HDR_SKIP_B:
                begin
                    if ((after_hdr == 16'd0) || in_ch.end_of_input)
                    begin
                        cmd.emit_end = 1'b1;
                    end
                    else
                    begin
                        payload_left_next = after_hdr;
                        state_next        = rdcs_pkg::HDR_PAYLOAD;
                    end
                end
                default:
                begin
                    cmd.emit_byte = 1'b1;
                    if ((after_byte == 16'd0) || in_ch.end_of_input)
                    begin
                        cmd.emit_end = 1'b1;
                    end
                    else
                    begin
                        payload_left_next = after_byte;
                    end
                end
            endcase

            // Drop back to header start at stream end or record close
            if (in_ch.end_of_input || cmd.emit_end)
            begin
                state_next        = rdcs_pkg::HDR_LEN_HI;
                length_high_next  = 8'd0;
                payload_left_next = 16'd0;
            end
        end

        if (!accept)
        begin
            state_next        = state_reg;
            length_high_next  = length_high_reg;
            payload_left_next = payload_left_reg;
        end
    end

    assign push = accept && (cmd.emit_byte || cmd.emit_end);

endmodule

// ===== design/rdcs_queue.sv =====
// Short command queue between the front and the back end.
`timescale 1ns / 1ps

module rdcs_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rdcs_pkg::cmd_t wdata,
    input  logic           pop,
    output rdcs_pkg::cmd_t rdata,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rdcs_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/rdcs_back.sv =====
// Back end: turns queued commands into output items, byte first, then terminator.
`timescale 1ns / 1ps

module rdcs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  rdcs_pkg::cmd_t cmd,
    output logic           pop,
    rdcs_out_if.source     out_ch
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       replaced_reg, replaced_next;
    logic       end_reg, end_next;
    logic       pending_end_reg, pending_end_next;
    logic       slot_free;

    assign slot_free = !valid_reg || out_ch.ready;

    // Load the output register from the pending terminator or the queue head
    always_comb
    begin
        valid_next       = valid_reg;
        byte_next        = byte_reg;
        replaced_next    = replaced_reg;
        end_next         = end_reg;
        pending_end_next = pending_end_reg;
        pop              = 1'b0;
        if (slot_free)
        begin
            if (pending_end_reg)
            begin
                valid_next       = 1'b1;
                byte_next        = rdcs_pkg::NEWLINE_CODE;
                replaced_next    = 1'b0;
                end_next         = 1'b1;
                pending_end_next = 1'b0;
            end
            else if (!empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (cmd.emit_byte)
                begin
                    byte_next        = cmd.value;
                    replaced_next    = cmd.replaced;
                    end_next         = 1'b0;
                    pending_end_next = cmd.emit_end;
                end
                else
                begin
                    byte_next     = rdcs_pkg::NEWLINE_CODE;
                    replaced_next = 1'b0;
                    end_next      = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            pending_end_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            pending_end_reg <= pending_end_next;
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        replaced_reg <= replaced_next;
        end_reg      <= end_next;
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.out_byte     = byte_reg;
    assign out_ch.was_replaced = replaced_reg;
    assign out_ch.record_end   = end_reg;

endmodule

// ===== design/record_deframer_control_char_scrubber.sv =====
// Top level of the record deframer with control-character scrubber.
//
//   channel   role   payload                                    handshake
//   raw       in     data_byte[7:0], end_of_input               valid/ready
//   filtered  out    out_byte[7:0], was_replaced, record_end    valid/ready
//   cfg       in     data (direct_mode)                         valid/ready
//
// One byte is accepted per clock while the command queue has room; ready
// depends only on queue occupancy. Each byte yields zero, one or two output
// items; two-item bytes (last payload byte) hold the output side for the
// byte and its terminator, absorbed by the queue; outputs are registered.
// rst_n clears the parser state, the mode register (record mode) and the queue.
`timescale 1ns / 1ps

module record_deframer_control_char_scrubber #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    rdcs_in_if.sink     raw,
    rdcs_out_if.source  filtered,
    rdcs_cfg_if.sink    cfg
);

    rdcs_pkg::cmd_t push_cmd;
    rdcs_pkg::cmd_t head_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    // Parse headers and classify bytes
    rdcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (raw),
        .cfg_ch     (cfg),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Decouple front and back
    rdcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .pop   (pop),
        .rdata (head_cmd),
        .full  (full),
        .empty (empty)
    );

    // Emit output items
    rdcs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .cmd    (head_cmd),
        .pop    (pop),
        .out_ch (filtered)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the record deframer with control-character scrubber.
`timescale 1ns / 1ps

module tb;

    localparam int      CYCLE_LIMIT   = 250000;
    localparam int      SETTLE_CYCLES = 10;
    localparam int      PHASE_ITEMS   = 160;
    localparam int      PHASE_COUNT   = 7;
    localparam logic [7:0]  BLANK     = 8'd32;
    localparam logic [7:0]  TOP_KEEP  = 8'd128;
    localparam logic [7:0]  LINE_FEED = 8'd10;
    localparam logic [15:0] HDR_LEN   = 16'd4;
    localparam logic        MODE_RECORD = 1'b0;
    localparam logic        MODE_DIRECT = 1'b1;
    localparam logic [7:0]  WHITELIST [10] = '{
        8'd9, 8'd128, 8'd196, 8'd199, 8'd214, 8'd220, 8'd223, 8'd228, 8'd246, 8'd252
    };

    typedef struct packed {
        logic [7:0] value;
        logic       replaced;
        logic       closes;
    } scrub_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_byte_t;

    // Deframer/scrubber predictor plus the store of expected output items
    class scrub_scoreboard;
        logic                 direct;
        rdcs_pkg::hdr_state_t hdr_pos;
        logic [7:0]           len_hi;
        logic [15:0]          bytes_left;
        scrub_item_t          expected_q[$];
        int                   mismatches;
        int                   n_inputs;
        int                   n_results;
        int                   n_closes;
        int                   n_replaced;

        function new();
            direct     = MODE_RECORD;
            mismatches = 0;
            n_inputs   = 0;
            n_results  = 0;
            n_closes   = 0;
            n_replaced = 0;
            clear_record();
        endfunction

        function void clear_record();
            hdr_pos    = rdcs_pkg::HDR_LEN_HI;
            len_hi     = 8'd0;
            bytes_left = 16'd0;
        endfunction

        function void set_mode(logic m);
            direct = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Keep whitelist bytes, 32..128 and newline if keep_newline is set, blank the rest
        function scrub_item_t scrub(logic [7:0] b, logic keep_newline);
            scrub_item_t r;
            logic        keep;
            keep = keep_newline && (b == LINE_FEED);
            foreach (WHITELIST[i])
            begin
                if (b == WHITELIST[i])
                begin
                    keep = 1'b1;
                end
            end
            r.closes = 1'b0;
            if (!keep && ((b < BLANK) || (b > TOP_KEEP)))
            begin
                r.value    = BLANK;
                r.replaced = 1'b1;
            end
            else
            begin
                r.value    = b;
                r.replaced = 1'b0;
            end
            return r;
        endfunction

        function void push_close();
            scrub_item_t r;
            r.value    = LINE_FEED;
            r.replaced = 1'b0;
            r.closes   = 1'b1;
            expected_q.push_back(r);
        endfunction

        // Advance the record parser by one accepted item
        function void note_input(logic [7:0] b, logic last);
            n_inputs++;
            if (direct)
            begin
                expected_q.push_back(scrub(b, 1'b1));
                if (last)
                begin
                    clear_record();
                end
                return;
            end
            case (hdr_pos)
                rdcs_pkg::HDR_LEN_HI:
                begin
                    len_hi  = b;
                    hdr_pos = rdcs_pkg::HDR_LEN_LO;
                end
                rdcs_pkg::HDR_LEN_LO:
                begin
                    bytes_left = {len_hi, b};
                    hdr_pos    = rdcs_pkg::HDR_SKIP_A;
                end
                rdcs_pkg::HDR_SKIP_A:
                begin
                    hdr_pos = rdcs_pkg::HDR_SKIP_B;
                end
                rdcs_pkg::HDR_SKIP_B:
                begin
                    bytes_left = (bytes_left < HDR_LEN) ? 16'd0 : bytes_left - HDR_LEN;
                    if (bytes_left == 16'd0 || last)
                    begin
                        push_close();
                        clear_record();
                    end
                    else
                    begin
                        hdr_pos = rdcs_pkg::HDR_PAYLOAD;
                    end
                    return;
                end
                default:
                begin
                    expected_q.push_back(scrub(b, 1'b0));
                    if (bytes_left != 16'd0)
                    begin
                        bytes_left = bytes_left - 16'd1;
                    end
                    if (bytes_left == 16'd0 || last)
                    begin
                        push_close();
                        clear_record();
                    end
                    return;
                end
            endcase
            if (last)
            begin
                clear_record();
            end
        endfunction

        // Compare one output item against the oldest expectation
        function void check_result(logic [7:0] v, logic rep, logic rend);
            scrub_item_t e;
            n_results++;
            if (rend)
            begin
                n_closes++;
            end
            if (rep)
            begin
                n_replaced++;
            end
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output item: out_byte %0d was_replaced %0b record_end %0b",
                         $time, v, rep, rend);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value || rep !== e.replaced || rend !== e.closes)
            begin
                mismatches++;
                if (v !== e.value)
                begin
                    $display("%0t: out_byte expected %0d actual %0d", $time, e.value, v);
                end
                if (rep !== e.replaced)
                begin
                    $display("%0t: was_replaced expected %0b actual %0b", $time, e.replaced, rep);
                end
                if (rend !== e.closes)
                begin
                    $display("%0t: record_end expected %0b actual %0b", $time, e.closes, rend);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   mode_writes;
    logic [8:0] rx_tick = 9'd0;

    raw_byte_t       stim_q[$];
    scrub_scoreboard board = new();

    rdcs_in_if  raw_ch();
    rdcs_out_if res_ch();
    rdcs_cfg_if cfg_ch();

    record_deframer_control_char_scrubber u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw_ch),
        .filtered (res_ch),
        .cfg      (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycle_count, board.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the output side on a rotating pattern: open, random, sparse, long stalls
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 9'd1;
        case (rx_tick[8:7])
            2'd0:    res_ch.ready <= 1'b1;
            2'd1:    res_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    res_ch.ready <= (rx_tick[2:0] != 3'd0);
            default: res_ch.ready <= (rx_tick[4:3] == 2'd0);
        endcase
    end

    // Check every accepted output item
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            board.check_result(res_ch.out_byte, res_ch.was_replaced, res_ch.record_end);
        end
    end

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(32, 128));
            4, 5:       return 8'($urandom_range(0, 31));
            6, 7:       return 8'($urandom_range(129, 255));
            8:          return WHITELIST[$urandom_range(0, 9)];
            default:    return ($urandom_range(0, 1) != 0) ? LINE_FEED : 8'd0;
        endcase
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic last);
        raw_byte_t r;
        r.data = b;
        r.last = last;
        stim_q.push_back(r);
    endfunction

    // Queue a 4-byte header; the tail byte may end the stream
    function automatic void queue_header(logic [15:0] len, logic last_on_tail);
        queue_byte(len[15:8], 1'b0);
        queue_byte(len[7:0], 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
        queue_byte(8'($urandom_range(0, 255)), last_on_tail);
    endfunction

    // Send the queued items in bursts with random gaps
    task automatic send_stream();
        raw_byte_t r;
        int        burst_left;
        int        gap;
        burst_left = $urandom_range(1, 40);
        while (stim_q.size() != 0)
        begin
            r = stim_q.pop_front();
            raw_ch.valid        <= 1'b1;
            raw_ch.data_byte    <= r.data;
            raw_ch.end_of_input <= r.last;
            @(posedge clk);
            while (!raw_ch.ready)
            begin
                @(posedge clk);
            end
            board.note_input(r.data, r.last);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
                if (gap != 0)
                begin
                    raw_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        raw_ch.valid <= 1'b0;
    endtask

    // Wait for all expected items, then let in-flight header bytes clear
    task automatic settle();
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        board.set_mode(m);
        mode_writes++;
    endtask

    initial
    begin
        logic        mode;
        logic        fin;
        logic [7:0]  hi;
        logic [7:0]  lo;
        int          pick;
        int          n;
        rst_n               = 1'b0;
        mode_writes         = 0;
        raw_ch.valid        = 1'b0;
        raw_ch.data_byte    = 8'd0;
        raw_ch.end_of_input = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed record mode: short length, mixed payload, partial header,
        // header ending the stream, stream ending inside a long payload
        write_mode(MODE_RECORD);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h33, 1'b0);
        queue_byte(8'h44, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h09, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'h66, 1'b0);
        queue_byte(LINE_FEED, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hC4, 1'b0);
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h1F, 1'b1);
        send_stream();

        // Directed direct mode: newline kept, control and high bytes blanked
        settle();
        write_mode(MODE_DIRECT);
        queue_byte(LINE_FEED, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'hFF, 1'b1);
        send_stream();

        // Random phases, alternating the mode
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            mode = (p % 2 == 0) ? MODE_RECORD : MODE_DIRECT;
            write_mode(mode);
            while (stim_q.size() < PHASE_ITEMS)
            begin
                if (mode == MODE_DIRECT)
                begin
                    queue_byte(content_byte(), $urandom_range(0, 29) == 0);
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                    begin
                        // well-formed record, sometimes ending the stream
                        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(0, 12);
                        fin = ($urandom_range(0, 9) == 0);
                        queue_header(16'(n + 4), fin && n == 0);
                        for (int i = 0; i < n; i++)
                        begin
                            queue_byte(content_byte(), fin && i == n - 1);
                        end
                    end
                    else if (pick < 70)
                    begin
                        // length below the header size
                        queue_header(16'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
                    end
                    else if (pick < 80)
                    begin
                        // long record cut off by the end of the stream
                        hi = 8'($urandom_range(1, 255));
                        lo = 8'($urandom_range(0, 255));
                        n  = $urandom_range(0, 8);
                        queue_header({hi, lo}, n == 0);
                        for (int i = 0; i < n; i++)
                        begin
                            queue_byte(content_byte(), i == n - 1);
                        end
                    end
                    else if (pick < 90)
                    begin
                        // partial header dropped at the end of the stream
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++)
                        begin
                            queue_byte(8'($urandom_range(0, 255)), i == n - 1);
                        end
                    end
                    else
                    begin
                        // noise that knocks the parser out of step
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++)
                        begin
                            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
                        end
                    end
                end
            end
            send_stream();
        end

        settle();
        $display("Sent %0d input items over %0d mode writes; checked %0d output items",
                 board.n_inputs, mode_writes, board.n_results);
        $display("Output held %0d record terminators and %0d blanked bytes",
                 board.n_closes, board.n_replaced);
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
